[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, on the usual clk_i / rst_ni pair.
`define ASSERT_STD(name, prop) `ASSERT_CLK_RST(name, clk_i, rst_ni, prop)

`endif

[hw/rtl/usbreq_pkg.sv]
package usbreq_pkg;

  localparam int unsigned MaxEndpointDefault = 6;

  // Standard request codes (bRequest)
  localparam logic [7:0] ReqGetStatus        = 8'h00;
  localparam logic [7:0] ReqClearFeature     = 8'h01;
  localparam logic [7:0] ReqSetFeature       = 8'h03;
  localparam logic [7:0] ReqSetAddress       = 8'h05;
  localparam logic [7:0] ReqGetDescriptor    = 8'h06;
  localparam logic [7:0] ReqGetConfiguration = 8'h08;
  localparam logic [7:0] ReqSetConfiguration = 8'h09;

  // bmRequestType values
  localparam logic [7:0] TypeOutStdDevice   = 8'h00;
  localparam logic [7:0] TypeInStdDevice    = 8'h80;
  localparam logic [7:0] TypeInStdEndpoint  = 8'h82;
  localparam logic [7:0] TypeOutStdEndpoint = 8'h02;

  typedef enum logic [3:0] {
    ActUser       = 4'd0,
    ActDescriptor = 4'd1,
    ActAddress    = 4'd2,
    ActConfig     = 4'd3,
    ActReply      = 4'd4,
    ActStall      = 4'd5,
    ActHaltSet    = 4'd6,
    ActHaltClear  = 4'd7,
    ActReset      = 4'd8
  } action_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] req_value;
    logic [15:0] req_index;
    logic [15:0] req_length;
    logic        user_claimed;
    logic        setup_flag;
  } req_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  reply_lo;
    logic [7:0]  reply_hi;
    logic [1:0]  reply_count;
    logic [3:0]  target_endpoint;
    logic [6:0]  device_address;
    logic [7:0]  active_config;
    logic [15:0] request_length;
  } rsp_t;

endpackage

[hw/rtl/usb_standard_request_handler.sv]
// USB chapter 9 standard request handler for the control endpoint.
// Input channel (in_valid_i / in_stall_o / in_req_i): one beat is either a
// decoded setup packet or a bus reset event (cmd set). Output channel
// (out_valid_o / out_stall_i / out_rsp_o): exactly one result beat per input
// beat, in order, carrying the action taken, reply bytes, the endpoint whose
// halt changed and the device address and configuration after the beat.
// Pipeline: an input register, then a result register. Throughput: one beat
// per cycle while out_stall_i is low; the decode is a single combinational pass
// between the two registers, and the device state (address, configuration,
// halt bits) updates as a beat enters the result register, so back-to-back
// beats see each other's effects.
// Reset: both stages empty, address, configuration and all halt bits zero.
// Stall: while out_stall_i holds a valid result, the result stays put; the
// input stage keeps one more beat, then in_stall_o rises until the result
// is taken.
module usb_standard_request_handler import usbreq_pkg::*; #(
  parameter int unsigned MaxEndpoint = MaxEndpointDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  // Stage 1: input register
  logic s1_valid_q;
  req_t s1_req_q;
  // Stage 2: result register
  logic out_valid_q;
  rsp_t out_rsp_q;
  // Device state
  logic [6:0]             addr_q, addr_d;
  logic [7:0]             cfg_q, cfg_d;
  logic [MaxEndpoint-1:0] halt_q, halt_d;
  rsp_t                   rsp_d;

  logic out_free;  // result register can take a beat
  logic s1_adv;    // stage 1 beat moves to the result register
  logic in_take;   // input beat accepted

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  usbreq_dec #(
    .MaxEndpoint(MaxEndpoint)
  ) u_dec (
    .req_i (s1_req_q),
    .addr_i(addr_q),
    .cfg_i (cfg_q),
    .halt_i(halt_q),
    .addr_o(addr_d),
    .cfg_o (cfg_d),
    .halt_o(halt_d),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      cfg_q       <= '0;
      halt_q      <= '0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      // state commits with the beat that changes it
      if (s1_adv) begin
        addr_q <= addr_d;
        cfg_q  <= cfg_d;
        halt_q <= halt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[hw/rtl/usbreq_dec.sv]
// Request decode: one beat in, next device state and one result out.
module usbreq_dec import usbreq_pkg::*; #(
  parameter int unsigned MaxEndpoint = MaxEndpointDefault
) (
  input  req_t                   req_i,
  input  logic [6:0]             addr_i,
  input  logic [7:0]             cfg_i,
  input  logic [MaxEndpoint-1:0] halt_i,
  output logic [6:0]             addr_o,
  output logic [7:0]             cfg_o,
  output logic [MaxEndpoint-1:0] halt_o,
  output rsp_t                   rsp_o
);

  logic [6:0]             ep;
  logic [MaxEndpoint-1:0] ep_sel;
  logic                   ep_ok;
  logic                   ep_halted;

  assign ep = req_i.req_index[6:0];

  always_comb begin
    for (int unsigned e = 0; e < MaxEndpoint; e++) begin
      ep_sel[e] = (ep == 7'(e + 1));
    end
  end

  assign ep_ok     = |ep_sel;
  assign ep_halted = |(ep_sel & halt_i);

  always_comb begin
    rsp_o        = '0;
    rsp_o.action = ActStall;
    addr_o       = addr_i;
    cfg_o        = cfg_i;
    halt_o       = halt_i;
    if (req_i.cmd) begin
      addr_o       = '0;
      cfg_o        = '0;
      halt_o       = '0;
      rsp_o.action = ActReset;
    end else if (req_i.user_claimed) begin
      rsp_o.action = ActUser;
    end else if (req_i.setup_flag) begin
      unique case (req_i.request_code)
        ReqGetDescriptor: begin
          rsp_o.action         = ActDescriptor;
          rsp_o.request_length = req_i.req_length;
        end
        ReqSetAddress: begin
          addr_o       = req_i.req_value[6:0];
          rsp_o.action = ActAddress;
        end
        ReqSetConfiguration: begin
          if (req_i.request_type == TypeOutStdDevice) begin
            cfg_o        = req_i.req_value[7:0];
            rsp_o.action = ActConfig;
          end
        end
        ReqGetConfiguration: begin
          if (req_i.request_type == TypeInStdDevice) begin
            rsp_o.reply_lo    = cfg_i;
            rsp_o.reply_count = 2'd1;
            rsp_o.action      = ActReply;
          end
        end
        ReqGetStatus: begin
          // halt status only for a valid endpoint-recipient read
          rsp_o.reply_lo    = {7'd0, (req_i.request_type == TypeInStdEndpoint) && ep_halted};
          rsp_o.reply_count = 2'd2;
          rsp_o.action      = ActReply;
        end
        ReqClearFeature, ReqSetFeature: begin
          if (req_i.request_type == TypeOutStdEndpoint && req_i.req_value == 16'd0 &&
              ep_ok) begin
            if (req_i.request_code == ReqSetFeature) begin
              halt_o       = halt_i | ep_sel;
              rsp_o.action = ActHaltSet;
            end else begin
              halt_o       = halt_i & ~ep_sel;
              rsp_o.action = ActHaltClear;
            end
            rsp_o.target_endpoint = ep[3:0];
          end
        end
        default: begin
          rsp_o.action = ActStall;
        end
      endcase
    end
    rsp_o.device_address = addr_o;
    rsp_o.active_config  = cfg_o;
  end

endmodule

[hw/rtl/usbreq_chk.sv]
`include "assert_macros.svh"

module usbreq_chk import usbreq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  logic is_reply;
  logic has_bytes;
  logic is_reset;
  logic state_zero;
  logic halt_change;
  logic in_reset_beat;

  assign is_reply      = out_rsp_o.action == ActReply;
  assign has_bytes     = out_rsp_o.reply_count != 2'd0;
  assign is_reset      = out_rsp_o.action == ActReset;
  assign state_zero    = out_rsp_o.device_address == 7'd0 && out_rsp_o.active_config == 8'd0;
  assign halt_change   = out_rsp_o.action == ActHaltSet || out_rsp_o.action == ActHaltClear;
  assign in_reset_beat = in_valid_i && !in_stall_o && in_req_i.cmd;

  // held result must not move
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))

  // reply bytes only on a reply action
  `ASSERT_STD(a_reply_count, out_valid_o |-> (is_reply == has_bytes))

  // bus reset result shows cleared state
  `ASSERT_STD(a_reset_clears, out_valid_o && is_reset |-> state_zero)

  // an endpoint is named only when its halt changed
  `ASSERT_STD(a_target, out_valid_o && out_rsp_o.target_endpoint != 4'd0 |-> halt_change)

  // a bus reset accepted with the result register empty shows up as a reset result
  // after the input register, provided any beat ahead of it is taken on the next edge
  `ASSERT_STD(a_reset_latency, in_reset_beat && !out_valid_o ##1 !out_stall_i |=> out_valid_o && is_reset)

endmodule

bind usb_standard_request_handler usbreq_chk u_chk (.*);

[verif/testbench.sv]
module testbench import usbreq_pkg::*;;

  // Run length and watchdog
  localparam int unsigned RandomBeats = 1600;
  localparam int unsigned QuietFrom   = 1400;  // no idling on either side past this beat
  localparam int unsigned HoldAt      = 300;   // long receiver hold-off starts here
  localparam int unsigned DrainAt     = 700;   // sender waits for all results here
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxEp       = MaxEndpointDefault;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  usb_standard_request_handler i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the device state, advanced as each beat is accepted.
  logic [6:0]  dev_addr   = '0;
  logic [7:0]  dev_config = '0;
  logic [14:0] ep_halt    = '0;

  rsp_t        pending_rsp[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Idle control shared between the sender and the receiver.
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_seen  = 0;
  int unsigned hold_left   = 0;
  int unsigned rx_burst    = 0;

  // Directed vectors: expected result is typed in only where it is obvious.
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } vec_t;

  vec_t dir_vecs[$];

  // Expected response for one request; updates the shadow state.
  function automatic rsp_t decode_request(req_t r);
    rsp_t       p;
    logic [6:0] ep;
    logic       ep_ok;
    p        = '0;
    p.action = ActStall;
    ep       = r.req_index[6:0];
    ep_ok    = (ep >= 7'd1) && (ep <= 7'(MaxEp));
    if (r.cmd) begin
      // bus reset wipes everything, payload is don't-care
      dev_addr   = '0;
      dev_config = '0;
      ep_halt    = '0;
      p.action   = ActReset;
    end else if (r.user_claimed) begin
      p.action = ActUser;
    end else if (r.setup_flag) begin
      case (r.request_code)
        ReqGetDescriptor: begin
          p.action         = ActDescriptor;
          p.request_length = r.req_length;
        end
        ReqSetAddress: begin
          // any bmRequestType is taken
          dev_addr = r.req_value[6:0];
          p.action = ActAddress;
        end
        ReqSetConfiguration: begin
          if (r.request_type == TypeOutStdDevice) begin
            dev_config = r.req_value[7:0];
            p.action   = ActConfig;
          end
        end
        ReqGetConfiguration: begin
          if (r.request_type == TypeInStdDevice) begin
            p.reply_lo    = dev_config;
            p.reply_count = 2'd1;
            p.action      = ActReply;
          end
        end
        ReqGetStatus: begin
          // always answered; halt bit only for a valid endpoint request
          if (r.request_type == TypeInStdEndpoint && ep_ok) begin
            p.reply_lo = {7'd0, ep_halt[ep - 7'd1]};
          end
          p.reply_count = 2'd2;
          p.action      = ActReply;
        end
        ReqClearFeature, ReqSetFeature: begin
          if (r.request_type == TypeOutStdEndpoint && r.req_value == 16'd0 && ep_ok) begin
            ep_halt[ep - 7'd1] = (r.request_code == ReqSetFeature);
            p.action           = (r.request_code == ReqSetFeature) ? ActHaltSet : ActHaltClear;
            p.target_endpoint  = ep[3:0];
          end
        end
        default: ;
      endcase
    end
    p.device_address = dev_addr;
    p.active_config  = dev_config;
    return p;
  endfunction

  function automatic req_t mk_req(logic cmd, logic [7:0] rtype, logic [7:0] code,
                                  logic [15:0] value, logic [15:0] index,
                                  logic [15:0] len, logic claimed, logic setup);
    req_t r;
    r.cmd          = cmd;
    r.request_type = rtype;
    r.request_code = code;
    r.req_value    = value;
    r.req_index    = index;
    r.req_length   = len;
    r.user_claimed = claimed;
    r.setup_flag   = setup;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(action_e act, logic [7:0] lo, logic [1:0] cnt,
                                  logic [6:0] addr, logic [7:0] cfg, logic [15:0] len);
    rsp_t p;
    p                 = '0;
    p.action          = act;
    p.reply_lo        = lo;
    p.reply_count     = cnt;
    p.device_address  = addr;
    p.active_config   = cfg;
    p.request_length  = len;
    return p;
  endfunction

  task automatic add_vec(req_t r, bit typed, rsp_t t);
    vec_t v;
    v.req   = r;
    v.typed = typed;
    v.rsp   = t;
    dir_vecs.push_back(v);
  endtask

  // Mostly well-formed setup packets with random content, plus noise and
  // the odd bus reset. Every bit of every field gets exercised by the noise.
  function automatic req_t rand_request();
    req_t        r;
    int unsigned pick;
    logic [6:0]  ep;
    r.cmd          = 1'b0;
    r.request_type = 8'($urandom);
    r.request_code = 8'($urandom);
    r.req_value    = 16'($urandom);
    r.req_index    = 16'($urandom);
    r.req_length   = 16'($urandom);
    r.user_claimed = 1'($urandom);
    r.setup_flag   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.cmd = 1'b1;
    end else if (pick < 15) begin
      r.cmd = ($urandom_range(0, 7) == 0);
    end else begin
      r.user_claimed = ($urandom_range(0, 19) == 0);
      r.setup_flag   = ($urandom_range(0, 19) != 0);
      // endpoint 0..8 straddles the valid range; upper index bits sometimes junk
      ep          = 7'($urandom_range(0, MaxEp + 2));
      r.req_index = ($urandom_range(0, 3) == 0) ? {9'($urandom), ep} : {9'd0, ep};
      case ($urandom_range(0, 6))
        0: begin
          r.request_code = ReqGetStatus;
          r.request_type = ($urandom_range(0, 5) != 0) ? TypeInStdEndpoint : TypeInStdDevice;
        end
        1: begin
          r.request_code = ReqClearFeature;
          r.request_type = TypeOutStdEndpoint;
        end
        2: begin
          r.request_code = ReqSetFeature;
          r.request_type = TypeOutStdEndpoint;
        end
        3: r.request_code = ReqSetAddress;
        4: r.request_code = ReqGetDescriptor;
        5: begin
          r.request_code = ReqGetConfiguration;
          r.request_type = TypeInStdDevice;
        end
        default: begin
          r.request_code = ReqSetConfiguration;
          r.request_type = TypeOutStdDevice;
        end
      endcase
      // break the type or the feature selector now and then
      if (r.request_code == ReqClearFeature || r.request_code == ReqSetFeature) begin
        r.req_value = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'd0;
      end
      if ($urandom_range(0, 6) == 0) begin
        r.request_type = 8'($urandom);
      end
    end
    return r;
  endfunction

  // Drive one beat, hold it until accepted, record the expected response.
  // Returns at the falling edge after acceptance, maybe after an idle burst.
  task automatic send_beat(req_t r, bit typed, rsp_t t);
    rsp_t p;
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = decode_request(r);
    pending_rsp.push_back(typed ? t : p);
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected response has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  task automatic cmp_field(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off requested by the
  // sender side, counted here.
  always @(negedge clk_i) begin
    logic stall_nxt;
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      stall_nxt = 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
      rx_burst  = $urandom_range(1, 11) - 1;
      stall_nxt = 1'b1;
    end else begin
      stall_nxt = 1'b0;
    end
    out_stall_i <= stall_nxt;
  end

  // Result checker: every accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp_o);
        end
      end else begin
        want = pending_rsp.pop_front();
        cmp_field("action", want.action, out_rsp_o.action);
        cmp_field("reply_lo", want.reply_lo, out_rsp_o.reply_lo);
        cmp_field("reply_hi", want.reply_hi, out_rsp_o.reply_hi);
        cmp_field("reply_count", want.reply_count, out_rsp_o.reply_count);
        cmp_field("target_endpoint", want.target_endpoint, out_rsp_o.target_endpoint);
        cmp_field("device_address", want.device_address, out_rsp_o.device_address);
        cmp_field("active_config", want.active_config, out_rsp_o.active_config);
        cmp_field("request_length", want.request_length, out_rsp_o.request_length);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Directed vectors. Typed rows: after reset, extremes, clear-cut cases.
    // GetConfiguration straight out of reset reads zero
    add_vec(mk_req(1'b0, TypeInStdDevice, ReqGetConfiguration, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1),
            1'b1, mk_rsp(ActReply, 8'h00, 2'd1, 7'h00, 8'h00, 16'h0));
    // SetAddress takes any type; address keeps low 7 bits
    add_vec(mk_req(1'b0, 8'hFF, ReqSetAddress, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1),
            1'b1, mk_rsp(ActAddress, 8'h00, 2'd0, 7'h7F, 8'h00, 16'h0));
    add_vec(mk_req(1'b0, TypeOutStdDevice, ReqSetConfiguration, 16'hFFFF, 16'h0, 16'h0,
                   1'b0, 1'b1),
            1'b1, mk_rsp(ActConfig, 8'h00, 2'd0, 7'h7F, 8'hFF, 16'h0));
    add_vec(mk_req(1'b0, TypeInStdDevice, ReqGetConfiguration, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1),
            1'b1, mk_rsp(ActReply, 8'hFF, 2'd1, 7'h7F, 8'hFF, 16'h0));
    // bus reset with an all-ones payload
    add_vec(mk_req(1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1),
            1'b1, mk_rsp(ActReset, 8'h00, 2'd0, 7'h00, 8'h00, 16'h0));
    // user claim wins over everything but a bus reset, even a missing setup flag
    add_vec(mk_req(1'b0, 8'h00, ReqSetAddress, 16'h0055, 16'h0, 16'h0, 1'b1, 1'b1),
            1'b1, mk_rsp(ActUser, 8'h00, 2'd0, 7'h00, 8'h00, 16'h0));
    add_vec(mk_req(1'b0, 8'h00, ReqSetAddress, 16'h0055, 16'h0, 16'h0, 1'b1, 1'b0),
            1'b1, mk_rsp(ActUser, 8'h00, 2'd0, 7'h00, 8'h00, 16'h0));
    // no setup flag stalls
    add_vec(mk_req(1'b0, 8'h00, ReqSetAddress, 16'h0055, 16'h0, 16'h0, 1'b0, 1'b0),
            1'b1, mk_rsp(ActStall, 8'h00, 2'd0, 7'h00, 8'h00, 16'h0));
    add_vec(mk_req(1'b0, 8'h80, ReqGetDescriptor, 16'h0100, 16'h0, 16'hFFFF, 1'b0, 1'b1),
            1'b1, mk_rsp(ActDescriptor, 8'h00, 2'd0, 7'h00, 8'h00, 16'hFFFF));
    // wrong request types on the config requests stall
    add_vec(mk_req(1'b0, 8'h01, ReqSetConfiguration, 16'h0003, 16'h0, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, 8'h81, ReqGetConfiguration, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    // halt on the first and the last endpoint, then out-of-range and bad selectors
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqSetFeature, 16'h0, 16'h0081, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqSetFeature, 16'h0, 16'(MaxEp), 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqSetFeature, 16'h0, 16'(MaxEp + 1), 16'h0,
                   1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqSetFeature, 16'h0, 16'h0080, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqSetFeature, 16'h1, 16'h0002, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeInStdEndpoint, ReqSetFeature, 16'h0, 16'h0002, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    // GetStatus: halted endpoint, wrong type, junk upper index bits
    add_vec(mk_req(1'b0, TypeInStdEndpoint, ReqGetStatus, 16'h0, 16'h0081, 16'h2, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeInStdDevice, ReqGetStatus, 16'h0, 16'h0081, 16'h2, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeInStdEndpoint, ReqGetStatus, 16'h0, 16'hFF00 | 16'(MaxEp), 16'h2,
                   1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeOutStdEndpoint, ReqClearFeature, 16'h0, 16'h0001, 16'h0, 1'b0, 1'b1),
            1'b0, '0);
    add_vec(mk_req(1'b0, TypeInStdEndpoint, ReqGetStatus, 16'h0, 16'h0001, 16'h2, 1'b0, 1'b1),
            1'b0, '0);
    // unknown request codes
    add_vec(mk_req(1'b0, 8'h00, 8'hFF, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1), 1'b0, '0);
    add_vec(mk_req(1'b0, 8'h00, 8'h02, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1), 1'b0, '0);
    // bus reset with a zero payload clears the halt left on the last endpoint
    add_vec(mk_req(1'b1, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0),
            1'b1, mk_rsp(ActReset, 8'h00, 2'd0, 7'h00, 8'h00, 16'h0));

    // reset once, released on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (dir_vecs[k]) begin
      send_beat(dir_vecs[k].req, dir_vecs[k].typed, dir_vecs[k].rsp);
    end
    drain();

    for (int unsigned i = 0; i < RandomBeats; i++) begin
      // idle-free stretches every fourth block, during the hold-off and at the end
      tx_idle_en = (i < QuietFrom) && ((i / 120) % 4 != 3) && !(i >= HoldAt && i < HoldAt + 60);
      rx_idle_en = (i < QuietFrom) && ((i / 120) % 4 != 3);
      if (i == HoldAt) begin
        // receiver sits still while the sender keeps pushing: pipe fills up
        holds_asked++;
      end
      if (i == DrainAt) begin
        drain();
      end
      send_beat(rand_request(), 1'b0, '0);
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
